### hdl/cls_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_pkg
// Shared request codes, status codes and the cell control bundle.
// ----------------------------------------------------------------------------
package cls_pkg;

	// request kinds (s_tuser)
	localparam logic [2:0] KIND_APPEND      = 3'd0;
	localparam logic [2:0] KIND_REMOVE_AT   = 3'd1;
	localparam logic [2:0] KIND_REMOVE_LAST = 3'd2;
	localparam logic [2:0] KIND_READ_AT     = 3'd3;
	localparam logic [2:0] KIND_FIND        = 3'd4;

	// result status
	localparam logic [1:0] ST_OK      = 2'd0;
	localparam logic [1:0] ST_RANGE   = 2'd1;
	localparam logic [1:0] ST_FULL    = 2'd2;
	localparam logic [1:0] ST_MISSING = 2'd3;

	// per-beat command broadcast to every cell
	typedef struct packed {
		logic wr;    // store key at the cell whose position equals count
		logic shift; // cells at or above sel_pos take their upper neighbor
	} cls_ctrl_t;

endpackage

`default_nettype wire

### hdl/cls_cell.sv
`default_nettype none
// ----------------------------------------------------------------------------
// cls_cell
// One list slot: holds a value, compares it with the key, shifts down on
// removal and drives its value onto the read bus when selected.
// ----------------------------------------------------------------------------
module cls_cell #(
	parameter int CW  = 5,
	parameter int POS = 0
) (
	input  wire                    clk,
	input  wire cls_pkg::cls_ctrl_t ctrl,
	input  wire  [CW-1:0]          count,
	input  wire  [CW-1:0]          sel_pos,
	input  wire  signed [31:0]     key,
	input  wire  signed [31:0]     next_val,
	output logic signed [31:0]     val,
	output logic                   match,
	output logic signed [31:0]     rd_data
);

	localparam logic [CW-1:0] MY_POS = CW'(POS);

	logic signed [31:0] val_q;

	always_ff @(posedge clk) begin
		if (ctrl.wr && (count == MY_POS)) begin
			val_q <= key;
		end else if (ctrl.shift && (MY_POS >= sel_pos)) begin
			val_q <= next_val;
		end
	end

	assign val     = val_q;
	assign match   = (MY_POS < count) && (val_q == key);
	assign rd_data = (sel_pos == MY_POS) ? val_q : 32'sd0;

endmodule

`default_nettype wire

### hdl/compacting_list_store_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// compacting_list_store_top
// Ordered list of signed 32-bit values held in a row of slot cells; append,
// remove at index, remove last, read at index and find first match.
// ----------------------------------------------------------------------------
//
// channel  dir  fields (low bit first)
// -------  ---  ------------------------------------------------------------
// s_*      in   tdata: index[3:0], value[35:4], pad; tuser: kind[2:0]
// m_*      out  tdata: data[31:0], found_index[36:32], count[41:37], pad;
//               tuser: found[0], status[2:1]
//
// One request per clock while the output drains: every cell compares and shifts in
// the same cycle the beat is taken, and the list update and the result are both registered then.
// The result sits in an output register; a new beat is taken whenever that
// register is empty or being drained in the same cycle.
// Reset clears the entry count and the output valid; slot contents are not
// reset and are only read below the count.
// ----------------------------------------------------------------------------
module compacting_list_store_top #(
	parameter int CAPACITY = 16
) (
	input  wire         clk,
	input  wire         arst_n,
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [39:0] s_tdata,  // index[3:0], value[35:4], zero pad
	input  wire  [2:0]  s_tuser,  // kind[2:0]
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,  // data[31:0], found_index[36:32], count[41:37], pad
	output logic [2:0]  m_tuser   // found[0], status[2:1]
);

	// count width holds 0..CAPACITY; compare width covers the 4-bit index too
	localparam int CW = $clog2(CAPACITY + 1);
	localparam int WW = (CW > 4) ? CW : 4;
	localparam int FW = (CW > 5) ? CW : 5;
	localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

	logic [2:0]         kind;
	logic [3:0]         index;
	logic signed [31:0] value;

	assign kind  = s_tuser;
	assign index = s_tdata[3:0];
	assign value = s_tdata[35:4];

	logic [CW-1:0] count_q;

	// cell row
	cls_pkg::cls_ctrl_t ctrl;
	logic [CW-1:0]      sel_pos;
	logic signed [31:0] cell_val [CAPACITY];
	logic signed [31:0] cell_rd  [CAPACITY];
	logic [CAPACITY-1:0] cell_match;

	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic signed [31:0] nxt;
		if (i == CAPACITY - 1) begin : g_end
			assign nxt = 32'sd0;
		end else begin : g_mid
			assign nxt = cell_val[i+1];
		end
		cls_cell #(
			.CW (CW),
			.POS(i)
		) u_cell (
			.clk     (clk),
			.ctrl    (ctrl),
			.count   (count_q),
			.sel_pos (sel_pos),
			.key     (value),
			.next_val(nxt),
			.val     (cell_val[i]),
			.match   (cell_match[i]),
			.rd_data (cell_rd[i])
		);
	end

	// read bus: only the selected cell drives nonzero
	logic signed [31:0] rd_bus;
	always_comb begin
		rd_bus = 32'sd0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_bus = rd_bus | cell_rd[i];
		end
	end

	// first matching position
	logic [CW-1:0] hit_pos;
	always_comb begin
		hit_pos = '0;
		for (int i = CAPACITY - 1; i >= 0; i--) begin
			if (cell_match[i]) begin
				hit_pos = CW'(i);
			end
		end
	end

	logic [WW-1:0] idx_w;
	logic [WW-1:0] cnt_w;
	logic          idx_ok;
	logic          is_last;

	assign idx_w   = WW'(index);
	assign cnt_w   = WW'(count_q);
	assign idx_ok  = idx_w < cnt_w;
	assign is_last = (kind == cls_pkg::KIND_REMOVE_LAST);
	assign sel_pos = is_last ? (count_q - CW'(1)) : idx_w[CW-1:0];

	// request decode
	cls_pkg::cls_ctrl_t cmd;
	logic [CW-1:0]      cnt_nxt;
	logic signed [31:0] r_data;
	logic [4:0]         r_fidx;
	logic               r_found;
	logic [1:0]         r_status;
	logic [FW-1:0]      hit_ext;
	logic [FW-1:0]      cnt_ext;

	assign hit_ext = FW'(hit_pos);
	assign cnt_ext = FW'(cnt_nxt);

	always_comb begin
		cmd      = '0;
		cnt_nxt  = count_q;
		r_data   = 32'sd0;
		r_fidx   = 5'h1F;
		r_found  = 1'b0;
		r_status = cls_pkg::ST_OK;
		case (kind)
			cls_pkg::KIND_APPEND: begin
				if (count_q == CAP_C) begin
					r_status = cls_pkg::ST_FULL;
				end else begin
					cmd.wr  = 1'b1;
					cnt_nxt = count_q + CW'(1);
				end
			end
			cls_pkg::KIND_REMOVE_AT: begin
				if (!idx_ok) begin
					r_status = cls_pkg::ST_RANGE;
				end else begin
					r_data    = rd_bus;
					cmd.shift = 1'b1;
					cnt_nxt   = count_q - CW'(1);
				end
			end
			cls_pkg::KIND_REMOVE_LAST: begin
				if (count_q == '0) begin
					r_status = cls_pkg::ST_RANGE;
				end else begin
					r_data    = rd_bus;
					cmd.shift = 1'b1;
					cnt_nxt   = count_q - CW'(1);
				end
			end
			cls_pkg::KIND_READ_AT: begin
				if (!idx_ok) begin
					r_status = cls_pkg::ST_RANGE;
				end else begin
					r_data = rd_bus;
				end
			end
			cls_pkg::KIND_FIND: begin
				if (|cell_match) begin
					r_fidx  = hit_ext[4:0];
					r_found = 1'b1;
				end else begin
					r_status = cls_pkg::ST_MISSING;
				end
			end
			default: begin
				r_status = cls_pkg::ST_RANGE;
			end
		endcase
	end

	logic accept;
	logic m_tvalid_q;

	assign s_tready = !m_tvalid_q || m_tready;
	assign accept   = s_tvalid && s_tready;
	assign ctrl.wr    = accept && cmd.wr;
	assign ctrl.shift = accept && cmd.shift;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q    <= '0;
			m_tvalid_q <= 1'b0;
		end else begin
			if (accept) begin
				count_q <= cnt_nxt;
			end
			if (accept) begin
				m_tvalid_q <= 1'b1;
			end else if (m_tready) begin
				m_tvalid_q <= 1'b0;
			end
		end
	end

	// result payload
	logic [47:0] m_tdata_q;
	logic [2:0]  m_tuser_q;

	always_ff @(posedge clk) begin
		if (accept) begin
			m_tdata_q <= {6'd0, cnt_ext[4:0], r_fidx, r_data};
			m_tuser_q <= {r_status, r_found};
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tuser  = m_tuser_q;

endmodule

`default_nettype wire

### dv/compacting_list_store_top_test.sv
// ----------------------------------------------------------------------------
// compacting_list_store_top_test
// Self-checking bench for the compacting list store: a table of directed
// requests, then random request streams under several idle/stall patterns,
// every result checked field by field against a shadow copy of the list.
// ----------------------------------------------------------------------------
module compacting_list_store_top_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int CAPACITY     = 16;
	localparam int RANDOM_BEATS = 365;  // per idling phase
	localparam int QUIET_LIMIT  = 1000; // cycles with no beat on either side

	// kinds the block treats as unused
	localparam logic [2:0] KIND_SPARE_LO = 3'd5;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	localparam logic [4:0] NO_INDEX = 5'h1F; // -1 in five bits

	// one result beat, unpacked from m_tdata / m_tuser
	typedef struct packed {
		logic [31:0] data;
		logic [4:0]  found_index;
		logic        found;
		logic [1:0]  status;
		logic [4:0]  count;
	} list_result_t;

	// directed table row; typed rows carry their own expected result
	typedef struct packed {
		logic [2:0]   kind;
		logic [3:0]   index;
		logic [31:0]  value;
		logic [4:0]   reps;  // repeat count, value bumped by one each time
		logic         typed;
		list_result_t want;
	} request_row_t;

	localparam list_result_t UNTYPED = '0;
	localparam int NUM_DIRECTED = 18;

	localparam request_row_t DIRECTED [NUM_DIRECTED] = '{
		// empty list: every access is refused
		'{cls_pkg::KIND_REMOVE_LAST, 4'd0, 32'h0000_0000, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_RANGE, 5'd0}},
		'{cls_pkg::KIND_READ_AT, 4'd0, 32'h0000_0000, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_RANGE, 5'd0}},
		'{cls_pkg::KIND_FIND, 4'd0, 32'h0000_0000, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_MISSING, 5'd0}},
		'{KIND_SPARE_HI, 4'hF, 32'hFFFF_FFFF, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_RANGE, 5'd0}},
		// fill to capacity with the value extremes up front
		'{cls_pkg::KIND_APPEND, 4'd0, 32'h8000_0000, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_OK, 5'd1}},
		'{cls_pkg::KIND_APPEND, 4'hF, 32'h7FFF_FFFF, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_OK, 5'd2}},
		'{cls_pkg::KIND_APPEND, 4'd0, 32'h0000_0000, 5'd1, 1'b0, UNTYPED},
		'{cls_pkg::KIND_APPEND, 4'd0, 32'hFFFF_FFFF, 5'd1, 1'b0, UNTYPED},
		'{cls_pkg::KIND_APPEND, 4'd5, 32'h1234_5678, 5'd11, 1'b0, UNTYPED},
		// duplicate at 15
		'{cls_pkg::KIND_APPEND, 4'd0, 32'h7FFF_FFFF, 5'd1, 1'b0, UNTYPED},
		// full list refuses the append
		'{cls_pkg::KIND_APPEND, 4'd0, 32'h0000_0005, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_FULL, 5'd16}},
		// first match wins
		'{cls_pkg::KIND_FIND, 4'd0, 32'h7FFF_FFFF, 5'd1, 1'b0, UNTYPED},
		'{cls_pkg::KIND_READ_AT, 4'hF, 32'h0000_0000, 5'd1, 1'b0, UNTYPED},
		'{cls_pkg::KIND_FIND, 4'd0, 32'h0BAD_CAFE, 5'd1, 1'b0, UNTYPED},
		// full shift
		'{cls_pkg::KIND_REMOVE_AT, 4'd0, 32'h0000_0000, 5'd1, 1'b0, UNTYPED},
		// index 15 is now past the end
		'{cls_pkg::KIND_REMOVE_AT, 4'hF, 32'h0000_0000, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_RANGE, 5'd15}},
		'{cls_pkg::KIND_REMOVE_LAST, 4'd0, 32'h0000_0000, 5'd1, 1'b0, UNTYPED},
		'{KIND_SPARE_LO, 4'd0, 32'h0000_0000, 5'd1, 1'b1,
			'{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_RANGE, 5'd14}}
	};

	// ------------------------------------------------------------------
	// clock, reset, block ports
	// ------------------------------------------------------------------
	logic        clk      = 1'b0;
	logic        arst_n   = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [39:0] s_tdata  = '0;  // index[3:0], value[35:4], pad
	logic [2:0]  s_tuser  = '0;  // kind[2:0]
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [47:0] m_tdata;        // data[31:0], found_index[36:32], count[41:37], pad
	logic [2:0]  m_tuser;        // found[0], status[2:1]

	always begin
		#6ns clk = 1'b1;
		#6ns clk = 1'b0;
	end

	compacting_list_store_top #(.CAPACITY(CAPACITY)) dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// ------------------------------------------------------------------
	// shadow list and the results it says are due
	// ------------------------------------------------------------------
	logic [31:0]  shadow_vals [CAPACITY];
	int           shadow_len = 0;
	list_result_t awaited_results [$];

	int send_idle_pct = 0;
	int stall_pct     = 0;
	int fill_goal     = 0;

	int mismatches    = 0;
	int beats_in      = 0;
	int beats_out     = 0;
	int full_refusals = 0;
	int range_errors  = 0;
	int find_hits     = 0;
	int find_misses   = 0;
	int peak_len      = 0;

	// Applies one request to the shadow list and returns the result it owes.
	// Slots at or above shadow_len are never read.
	function automatic list_result_t apply_request(input logic [2:0] kind,
		input logic [3:0] idx, input logic [31:0] val);
		list_result_t res;
		res = '{32'h0, NO_INDEX, 1'b0, cls_pkg::ST_OK, 5'd0};
		case (kind)
			cls_pkg::KIND_APPEND: begin
				if (shadow_len >= CAPACITY) begin
					res.status = cls_pkg::ST_FULL;
				end else begin
					shadow_vals[shadow_len] = val;
					shadow_len++;
				end
			end
			cls_pkg::KIND_REMOVE_AT, cls_pkg::KIND_READ_AT: begin
				if (int'(idx) >= shadow_len) begin
					res.status = cls_pkg::ST_RANGE;
				end else begin
					res.data = shadow_vals[idx];
					if (kind == cls_pkg::KIND_REMOVE_AT) begin
						for (int j = idx; j < shadow_len - 1; j++)
							shadow_vals[j] = shadow_vals[j + 1];
						shadow_len--;
					end
				end
			end
			cls_pkg::KIND_REMOVE_LAST: begin
				if (shadow_len == 0) begin
					res.status = cls_pkg::ST_RANGE;
				end else begin
					res.data = shadow_vals[shadow_len - 1];
					shadow_len--;
				end
			end
			cls_pkg::KIND_FIND: begin
				res.status = cls_pkg::ST_MISSING;
				for (int j = 0; j < shadow_len; j++) begin
					if (!res.found && shadow_vals[j] == val) begin
						res.found       = 1'b1;
						res.found_index = 5'(j);
						res.status      = cls_pkg::ST_OK;
					end
				end
			end
			default: begin
				res.status = cls_pkg::ST_RANGE;
			end
		endcase
		res.count = 5'(shadow_len);
		return res;
	endfunction

	// Drives one request beat at the falling edge, holds it until taken, then
	// queues what the shadow list says should come back.
	task automatic send_request(input logic [2:0] kind, input logic [3:0] idx,
		input logic [31:0] val, input logic typed, input list_result_t want);
		list_result_t res;
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			s_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= kind;
		s_tdata  <= {4'b0, val, idx};
		do @(posedge clk); while (!s_tready);
		res = apply_request(kind, idx, val);
		awaited_results.push_back(typed ? want : res);
		beats_in++;
		if (res.status == cls_pkg::ST_FULL) full_refusals++;
		if (res.status == cls_pkg::ST_RANGE) range_errors++;
		if (kind == cls_pkg::KIND_FIND && res.found) find_hits++;
		if (kind == cls_pkg::KIND_FIND && !res.found) find_misses++;
		if (shadow_len > peak_len) peak_len = shadow_len;
	endtask

	// Drop valid and hold off until every owed result has drained.
	task automatic drain_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (awaited_results.size() != 0) @(negedge clk);
	endtask

	// Small pool gives plenty of duplicates so find has to pick the first one.
	function automatic logic [31:0] draw_value();
		logic [31:0] v;
		case ($urandom_range(9))
			0, 1, 2: v = 32'($urandom_range(7)) - 32'd4;
			3: begin
				case ($urandom_range(3))
					0: v = 32'h8000_0000;
					1: v = 32'h7FFF_FFFF;
					2: v = 32'h0000_0000;
					default: v = 32'hFFFF_FFFF;
				endcase
			end
			default: v = $urandom;
		endcase
		return v;
	endfunction

	// Random request steered toward fill_goal so the list sweeps empty..full.
	task automatic draw_request(output logic [2:0] kind, output logic [3:0] idx,
		output logic [31:0] val);
		int pick;
		pick = $urandom_range(99);
		if (shadow_len > 0 && $urandom_range(4) != 0)
			idx = 4'($urandom_range(shadow_len - 1));
		else
			idx = 4'($urandom_range(15));
		val = draw_value();
		if (pick < 3) begin
			kind = 3'($urandom_range(KIND_SPARE_HI, KIND_SPARE_LO));
		end else if (pick < 15) begin
			kind = cls_pkg::KIND_READ_AT;
		end else if (pick < 30) begin
			kind = cls_pkg::KIND_FIND;
			if (shadow_len > 0 && $urandom_range(9) < 6)
				val = shadow_vals[$urandom_range(shadow_len - 1)];
		end else if (shadow_len < fill_goal) begin
			kind = cls_pkg::KIND_APPEND;
		end else if (shadow_len > fill_goal) begin
			kind = $urandom_range(1) ? cls_pkg::KIND_REMOVE_AT
				: cls_pkg::KIND_REMOVE_LAST;
		end else begin
			case ($urandom_range(2))
				0: kind = cls_pkg::KIND_APPEND;
				1: kind = cls_pkg::KIND_REMOVE_AT;
				default: kind = cls_pkg::KIND_REMOVE_LAST;
			endcase
		end
	endtask

	task automatic report_mismatch(input string what, input logic [31:0] got,
		input logic [31:0] want);
		$display("[%0t] result %0d: %s got %h want %h", $realtime, beats_out,
			what, got, want);
		mismatches++;
	endtask

	// ------------------------------------------------------------------
	// receiver: random backpressure, set per phase
	// ------------------------------------------------------------------
	always @(negedge clk) begin
		m_tready <= ($urandom_range(99) >= stall_pct);
	end

	// ------------------------------------------------------------------
	// result checker: oldest owed result against each accepted beat
	// ------------------------------------------------------------------
	always @(posedge clk) begin
		list_result_t want;
		if (m_tvalid && m_tready) begin
			if (awaited_results.size() == 0) begin
				report_mismatch("unexpected beat, data", m_tdata[31:0], 32'h0);
			end else begin
				want = awaited_results.pop_front();
				if (m_tdata[31:0] !== want.data)
					report_mismatch("data", m_tdata[31:0], want.data);
				if (m_tdata[36:32] !== want.found_index)
					report_mismatch("found_index", 32'(m_tdata[36:32]),
						32'(want.found_index));
				if (m_tuser[0] !== want.found)
					report_mismatch("found", 32'(m_tuser[0]), 32'(want.found));
				if (m_tuser[2:1] !== want.status)
					report_mismatch("status", 32'(m_tuser[2:1]), 32'(want.status));
				if (m_tdata[41:37] !== want.count)
					report_mismatch("count", 32'(m_tdata[41:37]), 32'(want.count));
			end
			beats_out++;
		end
	end

	// ------------------------------------------------------------------
	// watchdog: too long with no beat on either channel ends the run
	// ------------------------------------------------------------------
	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < QUIET_LIMIT) begin
			@(posedge clk);
			if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
				quiet = 0;
			else
				quiet++;
		end
		$display("watchdog: no beat for %0d cycles, %0d results still owed",
			QUIET_LIMIT, awaited_results.size());
		$display("compacting_list_store_top regression: fail");
		$finish;
	end

	// ------------------------------------------------------------------
	// stimulus
	// ------------------------------------------------------------------
	initial begin : stimulus
		logic [2:0]  kind;
		logic [3:0]  idx;
		logic [31:0] val;
		int          send_pcts [5];
		int          stall_pcts [5];

		// idling phases: none, sender gaps, receiver stalls, both light, none
		send_pcts  = '{0, 45, 0, 6, 0};
		stall_pcts = '{0, 0, 45, 6, 0};

		repeat (10) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// directed table, no idling
		for (int r = 0; r < NUM_DIRECTED; r++) begin
			for (int k = 0; k < DIRECTED[r].reps; k++)
				send_request(DIRECTED[r].kind, DIRECTED[r].index,
					DIRECTED[r].value + 32'(k), DIRECTED[r].typed,
					DIRECTED[r].want);
		end

		// random phases; sender waits for a full drain at each boundary
		for (int p = 0; p < 5; p++) begin
			drain_results();
			send_idle_pct = send_pcts[p];
			stall_pct     = stall_pcts[p];
			for (int n = 0; n < RANDOM_BEATS; n++) begin
				if ($urandom_range(39) == 0 ||
					(shadow_len == fill_goal && $urandom_range(3) == 0)) begin
					case ($urandom_range(3))
						0: fill_goal = 0;
						1: fill_goal = CAPACITY;
						default: fill_goal = $urandom_range(CAPACITY);
					endcase
				end
				draw_request(kind, idx, val);
				send_request(kind, idx, val, 1'b0, UNTYPED);
			end
		end

		// wind down: let everything owed come back, then idle before the report
		@(negedge clk);
		s_tvalid <= 1'b0;
		stall_pct = 0;
		while (awaited_results.size() != 0) @(posedge clk);
		repeat (8) @(posedge clk);

		$display("%0d requests, %0d results checked; %0d full refusals, %0d range errors",
			beats_in, beats_out, full_refusals, range_errors);
		$display("finds: %0d hits, %0d misses; deepest fill %0d of %0d; %0d mismatches",
			find_hits, find_misses, peak_len, CAPACITY, mismatches);
		if (mismatches == 0)
			$display("compacting_list_store_top regression: pass");
		else
			$display("compacting_list_store_top regression: fail");
		$finish;
	end

endmodule

### filelist.f
hdl/cls_pkg.sv
hdl/cls_cell.sv
hdl/compacting_list_store_top.sv
dv/compacting_list_store_top_test.sv
